### rtl/psum_pkg.sv
// ----------------------------------------------------------------------------
// psum_pkg
// Control word, status and microprogram of the prime sum sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package psum_pkg;

  localparam int unsigned SUM_W = 28;
  localparam int unsigned UPC_W = 4;

  typedef logic [UPC_W-1:0] upc_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_LOAD,
    OP_NOP,
    OP_CLEAR,
    OP_SETP2,
    OP_MINIT,
    OP_MARK,
    OP_PINC,
    OP_ACC,
    OP_DONE
  } op_e;

  // jump conditions
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_NSTART,
    C_NLT2,
    C_SQGT,
    C_MARKED,
    C_MLE,
    C_PNE
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    upc_t  target;
  } ctrl_t;

  typedef struct packed {
    logic n_lt2;    // limit below two
    logic sq_gt_n;  // p*p beyond limit
    logic marked;   // sieve bit read for p
    logic m_le;     // m + p still within limit
    logic p_ne;     // p not yet at limit
  } stat_t;

  // microprogram step addresses
  localparam upc_t S_IDLE   = 4'd0;
  localparam upc_t S_CHK    = 4'd1;
  localparam upc_t S_CLEAR  = 4'd2;
  localparam upc_t S_SIEVE  = 4'd3;
  localparam upc_t S_TESTP  = 4'd4;
  localparam upc_t S_MINIT  = 4'd5;
  localparam upc_t S_MARK   = 4'd6;
  localparam upc_t S_NEXTP  = 4'd7;
  localparam upc_t S_SUMINI = 4'd8;
  localparam upc_t S_SUMRD  = 4'd9;
  localparam upc_t S_SUMACC = 4'd10;
  localparam upc_t S_DONE   = 4'd11;

  function automatic ctrl_t ucode(upc_t a);
    ctrl_t w;
    begin
      unique case (a)
        S_IDLE:   w = '{op: OP_LOAD,  cond: C_NSTART, target: S_IDLE};
        S_CHK:    w = '{op: OP_NOP,   cond: C_NLT2,   target: S_DONE};
        S_CLEAR:  w = '{op: OP_CLEAR, cond: C_PNE,    target: S_CLEAR};
        S_SIEVE:  w = '{op: OP_SETP2, cond: C_NONE,   target: S_IDLE};
        S_TESTP:  w = '{op: OP_NOP,   cond: C_SQGT,   target: S_SUMINI};
        S_MINIT:  w = '{op: OP_MINIT, cond: C_MARKED, target: S_NEXTP};
        S_MARK:   w = '{op: OP_MARK,  cond: C_MLE,    target: S_MARK};
        S_NEXTP:  w = '{op: OP_PINC,  cond: C_ALWAYS, target: S_TESTP};
        S_SUMINI: w = '{op: OP_SETP2, cond: C_NONE,   target: S_IDLE};
        S_SUMRD:  w = '{op: OP_NOP,   cond: C_NONE,   target: S_IDLE};
        S_SUMACC: w = '{op: OP_ACC,   cond: C_PNE,    target: S_SUMRD};
        S_DONE:   w = '{op: OP_DONE,  cond: C_ALWAYS, target: S_IDLE};
        default:  w = '{op: OP_NOP,   cond: C_ALWAYS, target: S_IDLE};
      endcase
      return w;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/psum_seq.sv
// ----------------------------------------------------------------------------
// psum_seq
// Step counter with conditional jumps; fetches the control word from the ROM.
// ----------------------------------------------------------------------------
`default_nettype none

module psum_seq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire psum_pkg::stat_t stat_i,
  output psum_pkg::ctrl_t      ctrl_o,
  output logic                 busy_o
);
  import psum_pkg::*;

  upc_t  upc_q, upc_d;
  ctrl_t w;
  logic  take;

  always_comb begin
    w = ucode(upc_q);
    unique case (w.cond)
      C_NONE:   take = 1'b0;
      C_ALWAYS: take = 1'b1;
      C_NSTART: take = !start_i;
      C_NLT2:   take = stat_i.n_lt2;
      C_SQGT:   take = stat_i.sq_gt_n;
      C_MARKED: take = stat_i.marked;
      C_MLE:    take = stat_i.m_le;
      C_PNE:    take = stat_i.p_ne;
      default:  take = 1'b0;
    endcase
    upc_d = take ? w.target : upc_q + upc_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o = w;
  assign busy_o = (upc_q != S_IDLE);

endmodule

`default_nettype wire

### rtl/psum_dp.sv
// ----------------------------------------------------------------------------
// psum_dp
// Sieve datapath: composite-bit memory, candidate and multiple registers,
// running square and saturating accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module psum_dp #(
  parameter int unsigned LIMIT_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic [LIMIT_WIDTH-1:0]        limit_i,
  input  wire psum_pkg::ctrl_t               ctrl_i,
  output psum_pkg::stat_t                    stat_o,
  output logic                               valid_o,
  output logic [psum_pkg::SUM_W-1:0]         prime_sum_o
);
  import psum_pkg::*;

  localparam int unsigned PW    = LIMIT_WIDTH + 1;
  localparam int unsigned SQW   = 2 * LIMIT_WIDTH + 3;
  localparam int unsigned DEPTH = 2 ** LIMIT_WIDTH;

  logic [LIMIT_WIDTH-1:0] n_q, n_d;
  logic [PW-1:0]          p_q, p_d;
  logic [PW-1:0]          m_q, m_d;
  logic [SQW-1:0]         sq_q, sq_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic                   rd_q;

  logic [PW-1:0]          n_ext;
  logic [PW:0]            m_next;
  logic [SUM_W:0]         sum_add;
  logic                   wr_en;
  logic                   wr_bit;
  logic [LIMIT_WIDTH-1:0] wr_addr;

  // one bit per number, set when composite
  logic mem_q [DEPTH];

  assign n_ext   = {1'b0, n_q};
  assign m_next  = {1'b0, m_q} + {1'b0, p_q};
  assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(p_q);

  always_comb begin
    n_d    = n_q;
    p_d    = p_q;
    m_d    = m_q;
    sq_d   = sq_q;
    sum_d  = sum_q;
    wr_en  = 1'b0;
    wr_bit = 1'b0;
    wr_addr = p_q[LIMIT_WIDTH-1:0];
    unique case (ctrl_i.op)
      OP_LOAD: begin
        n_d   = limit_i;
        p_d   = '0;
        sum_d = '0;
      end
      OP_CLEAR: begin
        wr_en = 1'b1;
        p_d   = p_q + PW'(1);
      end
      OP_SETP2: begin
        p_d  = PW'(2);
        sq_d = SQW'(4);
      end
      OP_MINIT: begin
        m_d = sq_q[PW-1:0];
      end
      OP_MARK: begin
        wr_en   = 1'b1;
        wr_bit  = 1'b1;
        wr_addr = m_q[LIMIT_WIDTH-1:0];
        m_d     = m_next[PW-1:0];
      end
      OP_PINC: begin
        // (p+1)^2 = p^2 + 2p + 1
        p_d  = p_q + PW'(1);
        sq_d = sq_q + SQW'({p_q, 1'b1});
      end
      OP_ACC: begin
        if (!rd_q) begin
          sum_d = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
        end
        p_d = p_q + PW'(1);
      end
      OP_NOP, OP_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    p_q   <= p_d;
    m_q   <= m_d;
    sq_q  <= sq_d;
    sum_q <= sum_d;
  end

  // sieve memory, read-first
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_bit;
    end
    rd_q <= mem_q[p_q[LIMIT_WIDTH-1:0]];
  end

  always_comb begin
    stat_o.n_lt2   = (n_q < LIMIT_WIDTH'(2));
    stat_o.sq_gt_n = (sq_q > SQW'(n_q));
    stat_o.marked  = rd_q;
    stat_o.m_le    = (m_next <= (PW+1)'(n_q));
    stat_o.p_ne    = (p_q != n_ext);
  end

  assign valid_o     = (ctrl_i.op == OP_DONE);
  assign prime_sum_o = sum_q;

endmodule

`default_nettype wire

### rtl/prime_sum_up_to_limit.sv
// ----------------------------------------------------------------------------
// prime_sum_up_to_limit
// Sum of all primes not above a limit, by a microcoded sieve of Eratosthenes.
//
//   channel   ports                     direction  beat taken when
//   request   start, busy, limit_i      in         start && !busy
//   result    valid_o, prime_sum_o      out        valid_o (one cycle)
//
// A request of limit n clears the sieve bits 0 to n, marks the multiples of
// each unmarked p from p*p up while p*p is within n, then sums the unmarked
// numbers 2 to n into the saturating accumulator and presents the result.
// Limits below two skip straight to the result. busy rises once a request is
// accepted and stays high through the result cycle, while no other is taken.
// Reset returns the step counter to idle; the sieve needs no clearing then.
// The result cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_sum_up_to_limit #(
  parameter int unsigned LIMIT_WIDTH = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [LIMIT_WIDTH-1:0]     limit_i,
  output logic                            valid_o,
  output logic [psum_pkg::SUM_W-1:0]      prime_sum_o
);
  import psum_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  psum_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  psum_dp #(
    .LIMIT_WIDTH (LIMIT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .limit_i     (limit_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .valid_o     (valid_o),
    .prime_sum_o (prime_sum_o)
  );

endmodule

`default_nettype wire
